/* rtl/mtlg_pkg.sv */
`default_nettype none
package mtlg_pkg;

    // Shape thresholds on a Q0.16 circularity score
    localparam logic [15:0] CIRCLE_MIN = 16'd60294;
    localparam logic [15:0] OVAL_MIN   = 16'd45876;

    localparam logic [1:0] CLS_CIRCLE = 2'd0;
    localparam logic [1:0] CLS_OVAL   = 2'd1;
    localparam logic [1:0] CLS_HOOK   = 2'd2;

    localparam logic [1:0] DISP_UNTESTED = 2'd0;
    localparam logic [1:0] DISP_PASS     = 2'd1;
    localparam logic [1:0] DISP_CHECK    = 2'd2;
    localparam logic [1:0] DISP_FAIL     = 2'd3;

    localparam logic CMD_MARKER = 1'b0;
    localparam logic CMD_EOF    = 1'b1;

    localparam logic KIND_MARKER  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_MISSED = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PASS_THR   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CHECK_THR  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_DIAG   = 3'd6;

    typedef struct packed {
        logic        command;
        logic [5:0]  marker_id;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] marker_radius;
        logic [15:0] circularity;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [5:0]  out_id;
        logic [1:0]  shape_class;
        logic [15:0] smooth_x;
        logic [15:0] smooth_y;
        logic [15:0] shown_score;
        logic [1:0]  disposition;
        logic [15:0] lens_score;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic        seen;
        logic [15:0] track_x;
        logic [15:0] track_y;
        logic [15:0] track_radius;
        logic [15:0] smoothed_score;
        logic [15:0] raw_score;
        logic [1:0]  track_class;
        logic        hook_forced;
        logic [7:0]  miss_count;
    } t_entry;

    function automatic logic [1:0] classify(input logic [15:0] s);
        logic [1:0] c;
        if (s >= CIRCLE_MIN) begin
            c = CLS_CIRCLE;
        end else if (s >= OVAL_MIN) begin
            c = CLS_OVAL;
        end else begin
            c = CLS_HOOK;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/mtlg_in_if.sv */
`default_nettype none
interface mtlg_in_if;
    logic                 valid;
    logic                 ready;
    mtlg_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/mtlg_out_if.sv */
`default_nettype none
interface mtlg_out_if;
    logic                 valid;
    logic                 ready;
    mtlg_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/mtlg_penalty.sv */
`default_nettype none
module mtlg_penalty (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_pos_x,
    input  logic [15:0]        i_pos_y,
    input  logic [15:0]        i_score,
    input  logic [15:0]        i_center_x,
    input  logic [15:0]        i_center_y,
    input  logic [23:0]        i_inv_diag,
    output logic               o_done,
    output logic signed [31:0] o_penalty
);

    localparam logic [3:0] P_IDLE = 4'd0;
    localparam logic [3:0] P_DX   = 4'd1;
    localparam logic [3:0] P_DY   = 4'd2;
    localparam logic [3:0] P_SQ   = 4'd3;
    localparam logic [3:0] P_RND  = 4'd4;
    localparam logic [3:0] P_WM   = 4'd5;
    localparam logic [3:0] P_WA   = 4'd6;
    localparam logic [3:0] P_M1   = 4'd7;
    localparam logic [3:0] P_M2   = 4'd8;
    localparam logic [3:0] P_FIN  = 4'd9;

    logic [3:0]         r_state;
    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    logic [16:0]        r_sc;
    logic [33:0]        r_sq;
    logic [33:0]        r_root;
    logic [33:0]        r_bit;
    logic [40:0]        r_dw;
    logic               r_neg;
    logic [41:0]        r_wabs;
    logic [40:0]        r_p1;
    logic [34:0]        r_p2;
    logic               r_done;
    logic signed [31:0] r_pen;

    logic signed [33:0] w_dx_sq;
    logic signed [33:0] w_dy_sq;
    logic [33:0]        w_trial;
    logic signed [42:0] w_w;
    logic signed [42:0] w_w_neg;
    logic [41:0]        w_rnd;
    logic [35:0]        w_mag;
    logic [30:0]        w_mag_sat;

    // Full-width squares of the offsets
    assign w_dx_sq = r_dx * r_dx;
    assign w_dy_sq = r_dy * r_dy;

    // Square root trial, signed weight and rounded magnitude
    assign w_trial   = r_root + r_bit;
    assign w_w       = 43'sh200_0000 - $signed({2'b00, r_dw});
    assign w_w_neg   = -w_w;
    assign w_rnd     = {1'b0, r_p1} + 42'h80_0000;
    assign w_mag     = {1'b0, r_p2} + {18'b0, w_rnd[41:24]};
    assign w_mag_sat = (|w_mag[35:31]) ? 31'h7FFF_FFFF : w_mag[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == P_FIN);
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_dx    <= $signed({1'b0, i_center_x}) - $signed({1'b0, i_pos_x});
                        r_dy    <= $signed({1'b0, i_center_y}) - $signed({1'b0, i_pos_y});
                        r_sc    <= 17'h1_0000 - {1'b0, i_score};
                        r_state <= P_DX;
                    end
                end
                P_DX: begin
                    r_sq    <= $unsigned(w_dx_sq);
                    r_state <= P_DY;
                end
                P_DY: begin
                    r_sq    <= r_sq + $unsigned(w_dy_sq);
                    r_root  <= '0;
                    r_bit   <= 34'h1_0000_0000;
                    r_state <= P_SQ;
                end
                // One root digit per cycle
                P_SQ: begin
                    if (r_bit == '0) begin
                        r_state <= P_RND;
                    end else begin
                        if (r_sq >= w_trial) begin
                            r_sq   <= r_sq - w_trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                P_RND: begin
                    if (r_sq > r_root) begin
                        r_root <= r_root + 34'd1;
                    end
                    r_state <= P_WM;
                end
                P_WM: begin
                    r_dw    <= {24'b0, r_root[16:0]} * {17'b0, i_inv_diag};
                    r_state <= P_WA;
                end
                P_WA: begin
                    r_neg   <= w_w[42];
                    r_wabs  <= w_w[42] ? w_w_neg[41:0] : w_w[41:0];
                    r_state <= P_M1;
                end
                P_M1: begin
                    r_p1    <= {17'b0, r_wabs[23:0]} * {24'b0, r_sc};
                    r_state <= P_M2;
                end
                P_M2: begin
                    r_p2    <= {17'b0, r_wabs[41:24]} * {18'b0, r_sc};
                    r_state <= P_FIN;
                end
                P_FIN: begin
                    r_pen   <= r_neg ? -$signed({1'b0, w_mag_sat}) : $signed({1'b0, w_mag_sat});
                    r_state <= P_IDLE;
                end
                default: begin
                    r_state <= P_IDLE;
                end
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_penalty = r_pen;

endmodule
`default_nettype wire

/* rtl/marker_track_and_lens_grade_core.sv */
`default_nettype none
// Marker request: table read, up to four smoothing steps (multiply, then add), a 17-step
//   distance root and the weight products; a new id skips the smoothing.
// End-of-frame request: a 23-step score divider (skipped for an empty frame, a hook or a
//   zero diagonal) and a table sweep of one entry per cycle.
// One request is worked at a time; a finished result waits in the output register.
// Synchronous active-low reset, then a clear of every table entry, taking no request.
module marker_track_and_lens_grade_core #(
    parameter int MAX_MARKERS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mtlg_in_if.sink                         i_in,
    mtlg_out_if.source                      o_out,
    input  logic                            i_cfg_wr_en,
    input  logic [mtlg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [mtlg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_MARKERS);
    localparam int CNT_W = $clog2(MAX_MARKERS + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_LD   = 4'd3;
    localparam logic [3:0] S_EM   = 4'd4;
    localparam logic [3:0] S_EA   = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_PEN  = 4'd7;
    localparam logic [3:0] S_MOUT = 4'd8;
    localparam logic [3:0] S_G0   = 4'd9;
    localparam logic [3:0] S_G1   = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_SW   = 4'd12;
    localparam logic [3:0] S_VOUT = 4'd13;

    // Configuration registers
    logic [15:0] r_alpha;
    logic [7:0]  r_max_missed;
    logic [15:0] r_pass_thr;
    logic [15:0] r_check_thr;
    logic [15:0] r_center_x;
    logic [15:0] r_center_y;
    logic [23:0] r_inv_diag;

    mtlg_pkg::t_entry r_track_mem [MAX_MARKERS];
    mtlg_pkg::t_entry r_rd_data;
    mtlg_pkg::t_entry r_ent;
    mtlg_pkg::t_entry n_ent;

    logic [3:0]          r_state;
    mtlg_pkg::t_in_item  r_in;
    logic [IDX_W-1:0]    r_k;
    logic [1:0]          r_step;
    logic signed [33:0]  r_prod;
    logic [1:0]          r_cls;
    logic [15:0]         r_shown;
    logic signed [31:0]  r_psum;
    logic [6:0]          r_fcnt;
    logic                r_fhook;
    logic [1:0]          r_disp;
    logic [15:0]         r_ls;
    logic [22:0]         r_s;
    logic [6:0]          r_rem;
    logic [4:0]          r_dcnt;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_pend;
    logic [IDX_W-1:0]    r_paddr;
    logic                r_ov;
    mtlg_pkg::t_out_item r_od;

    logic [IDX_W-1:0]    w_id_map [64];
    logic [IDX_W-1:0]    w_rd_addr;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    mtlg_pkg::t_entry    w_wr_data;
    mtlg_pkg::t_entry    w_aged;
    logic [7:0]          w_miss_inc;
    logic [15:0]         w_ema_in;
    logic [15:0]         w_ema_old;
    logic signed [16:0]  w_ema_diff;
    logic signed [34:0]  w_ema_sum;
    logic [15:0]         w_ema_res;
    logic                w_circ_hook;
    logic [1:0]          w_cls;
    logic [15:0]         w_shown;
    logic                w_out_free;
    logic                w_od_load;
    logic                w_pen_done;
    logic signed [31:0]  w_pen;
    logic signed [32:0]  w_psum_add;
    logic signed [31:0]  w_psum_sat;
    logic [22:0]         w_maxs;
    logic signed [33:0]  w_sdiff;
    logic [22:0]         w_s_clamp;
    logic [22:0]         w_pass_lim;
    logic [22:0]         w_check_lim;
    logic [7:0]          w_rem2;
    logic                w_qbit;
    logic [22:0]         w_q_next;
    mtlg_pkg::t_entry    w_new_ent;

    // Map a marker id onto a table row
    for (genvar g = 0; g < 64; g++) begin : g_id_map
        assign w_id_map[g] = IDX_W'(g % MAX_MARKERS);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha      <= 16'd19661;
            r_max_missed <= 8'd5;
            r_pass_thr   <= 16'd58982;
            r_check_thr  <= 16'd45875;
            r_center_x   <= 16'd5120;
            r_center_y   <= 16'd3840;
            r_inv_diag   <= 24'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                mtlg_pkg::REG_ALPHA:      r_alpha      <= i_cfg_wdata[15:0];
                mtlg_pkg::REG_MAX_MISSED: r_max_missed <= i_cfg_wdata[7:0];
                mtlg_pkg::REG_PASS_THR:   r_pass_thr   <= i_cfg_wdata[15:0];
                mtlg_pkg::REG_CHECK_THR:  r_check_thr  <= i_cfg_wdata[15:0];
                mtlg_pkg::REG_CENTER_X:   r_center_x   <= i_cfg_wdata[15:0];
                mtlg_pkg::REG_CENTER_Y:   r_center_y   <= i_cfg_wdata[15:0];
                mtlg_pkg::REG_INV_DIAG:   r_inv_diag   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Track table: one read port, one write port
    assign w_rd_addr = (r_state == S_SW) ? r_cnt[IDX_W-1:0] : r_k;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_track_mem[w_rd_addr];
        if (w_wr_en) begin
            r_track_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // Age an entry during the end-of-frame sweep
    always_comb begin
        w_aged     = r_rd_data;
        w_miss_inc = (r_rd_data.miss_count == 8'hFF) ? 8'hFF : r_rd_data.miss_count + 8'd1;
        if (r_rd_data.valid && !r_rd_data.seen) begin
            w_aged.miss_count = w_miss_inc;
            if (w_miss_inc > r_max_missed) begin
                w_aged.valid = 1'b0;
            end
        end
        w_aged.seen = 1'b0;
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_k;
        w_wr_data = r_ent;
        unique case (r_state)
            S_CLR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt[IDX_W-1:0];
                w_wr_data = '0;
            end
            S_WR: begin
                w_wr_en = 1'b1;
            end
            S_SW: begin
                w_wr_en   = r_pend;
                w_wr_addr = r_paddr;
                w_wr_data = w_aged;
            end
            default: begin
            end
        endcase
    end

    // Shared smoothing unit: old + alpha*(new - old), rounded
    always_comb begin
        case (r_step)
            2'd0: begin
                w_ema_in  = r_in.pos_x;
                w_ema_old = r_ent.track_x;
            end
            2'd1: begin
                w_ema_in  = r_in.pos_y;
                w_ema_old = r_ent.track_y;
            end
            2'd2: begin
                w_ema_in  = r_in.marker_radius;
                w_ema_old = r_ent.track_radius;
            end
            default: begin
                w_ema_in  = r_in.circularity;
                w_ema_old = r_ent.smoothed_score;
            end
        endcase
    end

    assign w_ema_diff  = $signed({1'b0, w_ema_in}) - $signed({1'b0, w_ema_old});
    assign w_ema_sum   = $signed({3'b000, w_ema_old, 16'h0000}) + 35'(r_prod) + 35'sd32768;
    assign w_ema_res   = w_ema_sum[31:16];
    assign w_circ_hook = (mtlg_pkg::classify(r_in.circularity) == mtlg_pkg::CLS_HOOK);

    // Fresh entry from a first reading
    always_comb begin
        w_new_ent                = '0;
        w_new_ent.valid          = 1'b1;
        w_new_ent.seen           = 1'b1;
        w_new_ent.track_x        = r_in.pos_x;
        w_new_ent.track_y        = r_in.pos_y;
        w_new_ent.track_radius   = r_in.marker_radius;
        w_new_ent.smoothed_score = r_in.circularity;
        w_new_ent.raw_score      = r_in.circularity;
        w_new_ent.track_class    = mtlg_pkg::classify(r_in.circularity);
        w_new_ent.hook_forced    = w_circ_hook;
    end

    // Next working entry: load from the table or start fresh, then fold in one smoothing step at a time
    always_comb begin
        n_ent = r_ent;
        if (r_state == S_LD) begin
            if (!r_rd_data.valid) begin
                n_ent = w_new_ent;
            end else begin
                n_ent            = r_rd_data;
                n_ent.seen       = 1'b1;
                n_ent.miss_count = '0;
            end
        end else if (r_state == S_EA) begin
            case (r_step)
                2'd0: n_ent.track_x      = w_ema_res;
                2'd1: n_ent.track_y      = w_ema_res;
                2'd2: n_ent.track_radius = w_ema_res;
                default: begin
                    n_ent.smoothed_score = w_ema_res;
                    n_ent.track_class    = mtlg_pkg::classify(w_ema_res);
                    n_ent.hook_forced    = 1'b0;
                end
            endcase
            if (r_step == 2'd2 && w_circ_hook) begin
                // hook reading: keep raw score, skip score smoothing
                n_ent.hook_forced = 1'b1;
                n_ent.raw_score   = r_in.circularity;
            end
        end
    end

    assign w_cls   = r_ent.hook_forced ? mtlg_pkg::CLS_HOOK : r_ent.track_class;
    assign w_shown = r_ent.hook_forced ? r_ent.raw_score : r_ent.smoothed_score;

    mtlg_penalty u_penalty (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_WR),
        .i_pos_x    (r_ent.track_x),
        .i_pos_y    (r_ent.track_y),
        .i_score    (w_shown),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_inv_diag (r_inv_diag),
        .o_done     (w_pen_done),
        .o_penalty  (w_pen)
    );

    // Saturating penalty accumulate
    assign w_psum_add = 33'(r_psum) + 33'(w_pen);
    always_comb begin
        if (w_psum_add[32] != w_psum_add[31]) begin
            w_psum_sat = w_psum_add[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_psum_sat = w_psum_add[31:0];
        end
    end

    // Frame score, clamped to [0, count * 65536]
    assign w_maxs  = {r_fcnt, 16'h0000};
    assign w_sdiff = $signed({11'b0, w_maxs}) - 34'(r_psum);
    always_comb begin
        if (w_sdiff < 0) begin
            w_s_clamp = '0;
        end else if (w_sdiff > $signed({11'b0, w_maxs})) begin
            w_s_clamp = w_maxs;
        end else begin
            w_s_clamp = w_sdiff[22:0];
        end
    end

    assign w_pass_lim  = {7'b0, r_pass_thr} * {16'b0, r_fcnt};
    assign w_check_lim = {7'b0, r_check_thr} * {16'b0, r_fcnt};

    // Restoring divide step: score by frame count
    assign w_rem2   = {r_rem, r_s[22]};
    assign w_qbit   = (w_rem2 >= {1'b0, r_fcnt});
    assign w_q_next = {r_s[21:0], w_qbit};

    assign w_out_free = !r_ov || o_out.ready;
    assign w_od_load  = ((r_state == S_MOUT) || (r_state == S_VOUT)) && w_out_free;

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_od_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_psum  <= '0;
            r_fcnt  <= '0;
            r_fhook <= 1'b0;
            r_disp  <= mtlg_pkg::DISP_UNTESTED;
            r_ls    <= '0;
        end else begin
            unique case (r_state)
                // Clear the table after reset
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MAX_MARKERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_in <= i_in.data;
                        r_k  <= w_id_map[i_in.data.marker_id];
                        r_state <= (i_in.data.command == mtlg_pkg::CMD_EOF) ? S_G0 : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_ent <= n_ent;
                    if (!r_rd_data.valid) begin
                        r_state <= S_WR;
                    end else begin
                        r_step  <= 2'd0;
                        r_state <= S_EM;
                    end
                end
                S_EM: begin
                    r_prod  <= $signed({1'b0, r_alpha}) * w_ema_diff;
                    r_state <= S_EA;
                end
                S_EA: begin
                    r_ent <= n_ent;
                    if (r_step == 2'd2 && w_circ_hook) begin
                        r_state <= S_WR;
                    end else if (r_step == 2'd3) begin
                        r_state <= S_WR;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= S_EM;
                    end
                end
                // Write back the entry and start the penalty unit
                S_WR: begin
                    r_cls   <= w_cls;
                    r_shown <= w_shown;
                    if (r_fcnt != 7'h7F) begin
                        r_fcnt <= r_fcnt + 7'd1;
                    end
                    if (w_cls == mtlg_pkg::CLS_HOOK) begin
                        r_fhook <= 1'b1;
                    end
                    r_state <= S_PEN;
                end
                S_PEN: begin
                    if (w_pen_done) begin
                        r_psum  <= w_psum_sat;
                        r_state <= S_MOUT;
                    end
                end
                S_MOUT: begin
                    if (w_out_free) begin
                        r_od <= '{kind:        mtlg_pkg::KIND_MARKER,
                                  out_id:      r_in.marker_id,
                                  shape_class: r_cls,
                                  smooth_x:    r_ent.track_x,
                                  smooth_y:    r_ent.track_y,
                                  shown_score: r_shown,
                                  disposition: mtlg_pkg::DISP_UNTESTED,
                                  lens_score:  '0};
                        r_state <= S_IDLE;
                    end
                end
                // Grade the frame
                S_G0: begin
                    r_cnt  <= '0;
                    r_pend <= 1'b0;
                    if (r_fcnt == '0) begin
                        r_disp  <= mtlg_pkg::DISP_UNTESTED;
                        r_ls    <= '0;
                        r_state <= S_SW;
                    end else if (r_fhook) begin
                        r_disp  <= mtlg_pkg::DISP_FAIL;
                        r_ls    <= '0;
                        r_state <= S_SW;
                    end else if (r_inv_diag == '0) begin
                        // hold the previous verdict
                        r_state <= S_SW;
                    end else begin
                        r_s     <= w_s_clamp;
                        r_state <= S_G1;
                    end
                end
                S_G1: begin
                    if (r_s >= w_pass_lim) begin
                        r_disp <= mtlg_pkg::DISP_PASS;
                    end else if (r_s >= w_check_lim) begin
                        r_disp <= mtlg_pkg::DISP_CHECK;
                    end else begin
                        r_disp <= mtlg_pkg::DISP_FAIL;
                    end
                    r_rem   <= '0;
                    r_dcnt  <= 5'd22;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_qbit ? 7'(w_rem2 - {1'b0, r_fcnt}) : w_rem2[6:0];
                    r_s    <= w_q_next;
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == '0) begin
                        r_ls    <= (|w_q_next[22:16]) ? 16'hFFFF : w_q_next[15:0];
                        r_state <= S_SW;
                    end
                end
                // Age the table, one entry per cycle
                S_SW: begin
                    if (r_cnt != CNT_W'(MAX_MARKERS)) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_pend  <= 1'b1;
                        r_paddr <= r_cnt[IDX_W-1:0];
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_psum  <= '0;
                            r_fcnt  <= '0;
                            r_fhook <= 1'b0;
                            r_state <= S_VOUT;
                        end
                    end
                end
                S_VOUT: begin
                    if (w_out_free) begin
                        r_od <= '{kind:        mtlg_pkg::KIND_VERDICT,
                                  out_id:      '0,
                                  shape_class: mtlg_pkg::CLS_CIRCLE,
                                  smooth_x:    '0,
                                  smooth_y:    '0,
                                  shown_score: '0,
                                  disposition: r_disp,
                                  lens_score:  r_ls};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
module tb_top;
    import mtlg_pkg::*;

    // Tracking table entry held by the predictor
    typedef struct {
        bit        valid;
        bit        seen;
        bit [15:0] x;
        bit [15:0] y;
        bit [15:0] rad;
        bit [15:0] sm_score;
        bit [15:0] raw;
        bit [1:0]  cls;
        bit        hook;
        bit [7:0]  miss;
    } track_t;

    // Predicts results and holds the expected queue
    class lens_grade_board;
        track_t          tbl[64];
        bit [15:0]       alpha, pass_thr, check_thr, cx, cy;
        bit [7:0]        max_miss;
        bit [23:0]       inv_diag;
        longint          pen_sum;
        int              frame_cnt;
        bit              has_hook;
        bit [1:0]        last_disp;
        bit [15:0]       last_score;
        t_out_item       pending[$];
        int              n_err;

        function void init();
            alpha = 19661; max_miss = 5; pass_thr = 58982; check_thr = 45875;
            cx = 5120; cy = 3840; inv_diag = 0;
            foreach (tbl[i]) tbl[i] = '{default: 0};
            pen_sum = 0; frame_cnt = 0; has_hook = 0;
            last_disp = DISP_UNTESTED; last_score = 0; n_err = 0;
        endfunction

        function void write_reg(bit [2:0] idx, bit [23:0] v);
            case (idx)
                REG_ALPHA:      alpha = v[15:0];
                REG_MAX_MISSED: max_miss = v[7:0];
                REG_PASS_THR:   pass_thr = v[15:0];
                REG_CHECK_THR:  check_thr = v[15:0];
                REG_CENTER_X:   cx = v[15:0];
                REG_CENTER_Y:   cy = v[15:0];
                REG_INV_DIAG:   inv_diag = v;
                default: ;
            endcase
        endfunction

        function bit [1:0] shape_of(bit [15:0] s);
            if (s >= 16'd60294) return CLS_CIRCLE;
            if (s >= 16'd45876) return CLS_OVAL;
            return CLS_HOOK;
        endfunction

        function bit [15:0] blend(bit [15:0] nv, bit [15:0] ov);
            longint unsigned v;
            v = longint'(alpha) * nv + (65536 - longint'(alpha)) * ov + 32768;
            return v[31:16];
        endfunction

        function longint unsigned root_rounded(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 40;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            if (v > r) r++;
            return r;
        endfunction

        function void accumulate_penalty(bit [15:0] px, bit [15:0] py, bit [15:0] s);
            longint dx, dy, w, p;
            longint unsigned d, mag;
            dx = longint'(cx) - longint'(px);
            dy = longint'(cy) - longint'(py);
            d = root_rounded(dx * dx + dy * dy);
            w = (longint'(2) << 24) - longint'(d * inv_diag);
            mag = (w < 0 ? -w : w) * (65536 - longint'(s));
            mag = (mag + (64'd1 << 23)) >> 24;
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            p = (w < 0 ? -longint'(mag) : longint'(mag)) + pen_sum;
            if (p > 64'sh7FFF_FFFF) p = 64'sh7FFF_FFFF;
            if (p < -64'sh8000_0000) p = -64'sh8000_0000;
            pen_sum = p;
        endfunction

        // Predict the result of one accepted request
        function void note_request(t_in_item it);
            t_out_item r;
            int k;
            r = '0;
            if (it.command == CMD_EOF) begin
                longint maxs, s;
                longint unsigned q;
                r.kind = KIND_VERDICT;
                if (frame_cnt == 0) begin
                    r.disposition = DISP_UNTESTED; r.lens_score = 0;
                end else if (has_hook) begin
                    r.disposition = DISP_FAIL; r.lens_score = 0;
                end else if (inv_diag == 0) begin
                    r.disposition = last_disp; r.lens_score = last_score;
                end else begin
                    maxs = longint'(frame_cnt) * 65536;
                    s = maxs - pen_sum;
                    if (s < 0) s = 0;
                    if (s > maxs) s = maxs;
                    if (s * 65536 >= longint'(pass_thr) * maxs) r.disposition = DISP_PASS;
                    else if (s * 65536 >= longint'(check_thr) * maxs)
                        r.disposition = DISP_CHECK;
                    else r.disposition = DISP_FAIL;
                    q = (s * 65536) / maxs;
                    r.lens_score = q > 65535 ? 16'hFFFF : q[15:0];
                end
                last_disp = r.disposition; last_score = r.lens_score;
                // age unseen entries and clear frame state
                foreach (tbl[i]) begin
                    if (tbl[i].valid && !tbl[i].seen) begin
                        if (tbl[i].miss != 8'hFF) tbl[i].miss++;
                        if (tbl[i].miss > max_miss) tbl[i].valid = 0;
                    end
                    tbl[i].seen = 0;
                end
                pen_sum = 0; frame_cnt = 0; has_hook = 0;
            end else begin
                k = it.marker_id;
                if (!tbl[k].valid) begin
                    tbl[k].valid = 1;
                    tbl[k].x = it.pos_x; tbl[k].y = it.pos_y; tbl[k].rad = it.marker_radius;
                    tbl[k].sm_score = it.circularity; tbl[k].raw = it.circularity;
                    tbl[k].cls = shape_of(it.circularity);
                    tbl[k].hook = (tbl[k].cls == CLS_HOOK);
                end else begin
                    tbl[k].x = blend(it.pos_x, tbl[k].x);
                    tbl[k].y = blend(it.pos_y, tbl[k].y);
                    tbl[k].rad = blend(it.marker_radius, tbl[k].rad);
                    if (shape_of(it.circularity) == CLS_HOOK) begin
                        tbl[k].hook = 1; tbl[k].raw = it.circularity;
                    end else begin
                        tbl[k].hook = 0;
                        tbl[k].sm_score = blend(it.circularity, tbl[k].sm_score);
                        tbl[k].cls = shape_of(tbl[k].sm_score);
                    end
                end
                tbl[k].miss = 0; tbl[k].seen = 1;
                r.kind = KIND_MARKER;
                r.out_id = it.marker_id;
                r.shape_class = tbl[k].hook ? CLS_HOOK : tbl[k].cls;
                r.smooth_x = tbl[k].x; r.smooth_y = tbl[k].y;
                r.shown_score = tbl[k].hook ? tbl[k].raw : tbl[k].sm_score;
                if (frame_cnt < 127) frame_cnt++;
                if (r.shape_class == CLS_HOOK) has_hook = 1;
                accumulate_penalty(r.smooth_x, r.smooth_y, r.shown_score);
            end
            pending = {pending, r};
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got); n_err++; return;
            end
            e = pending.pop_front();
            if (got.kind != e.kind) begin
                $error("kind exp %0d got %0d", e.kind, got.kind); n_err++; end
            if (got.out_id != e.out_id) begin
                $error("out_id exp %0d got %0d", e.out_id, got.out_id); n_err++; end
            if (got.shape_class != e.shape_class) begin
                $error("shape_class exp %0d got %0d", e.shape_class, got.shape_class);
                n_err++; end
            if (got.smooth_x != e.smooth_x) begin
                $error("smooth_x exp %0d got %0d", e.smooth_x, got.smooth_x); n_err++; end
            if (got.smooth_y != e.smooth_y) begin
                $error("smooth_y exp %0d got %0d", e.smooth_y, got.smooth_y); n_err++; end
            if (got.shown_score != e.shown_score) begin
                $error("shown_score exp %0d got %0d", e.shown_score, got.shown_score);
                n_err++; end
            if (got.disposition != e.disposition) begin
                $error("disposition exp %0d got %0d", e.disposition, got.disposition);
                n_err++; end
            if (got.lens_score != e.lens_score) begin
                $error("lens_score exp %0d got %0d", e.lens_score, got.lens_score);
                n_err++; end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic       cfg_we = 0;
    logic [2:0] cfg_addr = '0;
    logic [23:0] cfg_data = '0;
    int cycle_cnt = 0;
    int stall_mode = 0;
    lens_grade_board board;

    mtlg_in_if  req_ch();
    mtlg_out_if res_ch();

    marker_track_and_lens_grade_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_ch.sink), .o_out(res_ch.source),
        .i_cfg_wr_en(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Check results at each accepted handshake
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
    end

    // Stall the receiver on its own pattern
    always @(posedge i_clk) begin
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            2: res_ch.ready <= (cycle_cnt % 7 < 3);
            default: res_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Switch the stall pattern now and then
    always @(posedge i_clk) if (cycle_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);

    // Give up when the run hangs
    always @(posedge i_clk) begin
        if (cycle_cnt > 600000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(t_in_item it);
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(it);
    endtask

    task automatic go_idle(int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drop valid, wait out every expected result and the block's own tail
    task automatic drain();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0 && guard < 20000) begin
            @(posedge i_clk); guard++;
        end
        repeat (150) @(posedge i_clk);
    endtask

    // Write one register, then release the port
    task automatic write_reg(bit [2:0] idx, bit [23:0] v);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    function automatic t_in_item marker(bit [5:0] id, bit [15:0] x, bit [15:0] y,
                                        bit [15:0] r, bit [15:0] c);
        t_in_item it;
        it.command = CMD_MARKER; it.marker_id = id; it.pos_x = x; it.pos_y = y;
        it.marker_radius = r; it.circularity = c;
        return it;
    endfunction

    function automatic t_in_item end_frame();
        t_in_item it;
        it = '0;
        it.command = CMD_EOF;
        it.marker_id = 6'($urandom); it.pos_x = 16'($urandom);
        it.circularity = 16'($urandom);
        return it;
    endfunction

    function automatic bit [15:0] rand_circ();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(60294, 65535));
            1: return 16'($urandom_range(45876, 60293));
            2: return 16'($urandom_range(0, 45875));
            default: return 16'($urandom);
        endcase
    endfunction

    // Random frames of up to six markers, mostly on ids 0 to id_span, then end of frame
    task automatic random_frames(int n_items, int id_span);
        int sent, burst, nm;
        sent = 0; burst = $urandom_range(1, 12);
        while (sent < n_items) begin
            nm = $urandom_range(0, 6);
            for (int m = 0; m <= nm && sent < n_items; m++) begin
                t_in_item it;
                if (m == nm) it = end_frame();
                else if ($urandom_range(0, 9) == 0)
                    it = marker(6'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
                else
                    it = marker(6'($urandom_range(0, id_span)),
                                16'($urandom_range(3000, 7000)),
                                16'($urandom_range(2000, 6000)),
                                16'($urandom), rand_circ());
                send_request(it);
                sent++;
                if (--burst == 0) begin
                    go_idle($urandom_range(1, 40));
                    burst = $urandom_range(1, 12);
                end
            end
        end
        drain();
    endtask

    initial begin
        req_ch.valid = 0;
        req_ch.data = '0;
        board = new();
        board.init();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty frame, unset diagonal, hook, field extremes
        send_request(end_frame());
        send_request(marker(6'd0, 16'd0, 16'd0, 16'd0, 16'd65535));
        send_request(marker(6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd60294));
        send_request(end_frame());
        send_request(marker(6'd0, 16'd5120, 16'd3840, 16'd100, 16'd45876));
        send_request(marker(6'd0, 16'd5120, 16'd3840, 16'd100, 16'd45875));
        send_request(marker(6'd0, 16'd5120, 16'd3840, 16'd100, 16'd60293));
        send_request(end_frame());
        drain();
        write_reg(REG_INV_DIAG, 24'd2621);
        send_request(marker(6'd63, 16'd5120, 16'd3840, 16'd5, 16'd65535));
        send_request(marker(6'd5, 16'd0, 16'd0, 16'd5, 16'd60000));
        send_request(end_frame());
        send_request(marker(6'd7, 16'hFFFF, 16'd0, 16'd5, 16'd0));
        send_request(end_frame());
        // age everything out: max_missed 0 evicts after one unseen frame
        drain();
        write_reg(REG_MAX_MISSED, 24'd0);
        send_request(end_frame());
        send_request(end_frame());
        send_request(marker(6'd63, 16'd100, 16'd100, 16'd5, 16'd61000));
        send_request(end_frame());
        drain();

        // Pass through several register settings
        write_reg(REG_ALPHA, 24'd65535); write_reg(REG_MAX_MISSED, 24'd255);
        write_reg(REG_PASS_THR, 24'd0); write_reg(REG_CHECK_THR, 24'd0);
        write_reg(REG_CENTER_X, 24'd0); write_reg(REG_CENTER_Y, 24'hFFFF);
        write_reg(REG_INV_DIAG, 24'hFFFFFF);
        random_frames(100, 63);
        write_reg(REG_ALPHA, 24'd0); write_reg(REG_MAX_MISSED, 24'd2);
        write_reg(REG_PASS_THR, 24'hFFFF); write_reg(REG_CHECK_THR, 24'hFFFF);
        write_reg(REG_CENTER_X, 24'hFFFF); write_reg(REG_CENTER_Y, 24'd0);
        write_reg(REG_INV_DIAG, 24'd1);
        random_frames(100, 15);
        write_reg(REG_ALPHA, 24'd19661); write_reg(REG_MAX_MISSED, 24'd3);
        write_reg(REG_PASS_THR, 24'd58982); write_reg(REG_CHECK_THR, 24'd45875);
        write_reg(REG_CENTER_X, 24'd5120); write_reg(REG_CENTER_Y, 24'd3840);
        write_reg(REG_INV_DIAG, 24'd2621);
        random_frames(200, 7);
        write_reg(REG_INV_DIAG, 24'd700);
        write_reg(REG_PASS_THR, {8'd0, 16'($urandom)});
        write_reg(REG_CHECK_THR, {8'd0, 16'($urandom)});
        write_reg(REG_ALPHA, {8'd0, 16'($urandom)});
        random_frames(150, 31);

        if (board.n_err == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/mtlg_pkg.sv
rtl/mtlg_in_if.sv
rtl/mtlg_out_if.sv
rtl/mtlg_penalty.sv
rtl/marker_track_and_lens_grade_core.sv
dv/tb_top.sv
